@@ src/bounded_set_table_macros.svh @@
// assertion macros for the bounded set table rtl
`ifndef BOUNDED_SET_TABLE_MACROS_SVH
`define BOUNDED_SET_TABLE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define BST_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define BST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bst_pkg.sv @@
// shared types for the bounded set table
`default_nettype none

package bst_pkg;

  // operation carried in tuser
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  localparam int unsigned FieldBits = 6;

  // per-transfer control broadcast to every cell
  typedef struct packed {
    logic ins_en;  // store key at the cell whose index equals the fill count
    logic del_op;  // delete transfer: cells at or past the hit shift down
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/bounded_set_table.sv @@
// bounded set table: set of distinct values held in a row of cells
// usage
//   slave channel: one transfer per operation, tuser = mode (insert, delete,
//   query; code 3 behaves as a query), tdata = value to look up
//   master channel: exactly one result transfer per operation
//   every cell compares its entry with the value in the same cycle; a hit
//   flag ripples along the row so that on a delete each cell at or past the
//   hit takes its upper neighbor's entry, and an insert writes the cell that
//   sits at the fill count
//   the result is registered and shows on the master side in the cycle after
//   the input transfer; one operation per cycle is taken while the receiver
//   keeps up, as each needs a single compare-and-shift pass through the row
//   the next operation sees the table as the previous one left it
//   stall: while a result waits and the receiver holds tready low, the slave
//   tready drops; the pending result and table contents stay put
//   reset: fill count cleared, output register empty; entry contents are not
//   cleared since only entries below the fill count are ever looked at
`default_nettype none
`include "bounded_set_table_macros.svh"

module bounded_set_table #(
  parameter int unsigned CAPACITY_ENTRIES = 32,
  parameter int unsigned VALUE_BITS       = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // operation in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] item_value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
  // result out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [0] found, [6:1] position,
                                           // [12:7] fill_count, [13] changed,
                                           // [14] full_res, [15] zero
);

  localparam int unsigned CntW = $clog2(CAPACITY_ENTRIES + 1);
  localparam int unsigned FW   = bst_pkg::FieldBits;

  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  logic [15:0]           out_data_q, out_data_d;

  logic [VALUE_BITS-1:0] key;
  bst_pkg::mode_e        mode;
  logic                  s_fire;
  logic                  found;
  logic                  ins_go;
  logic                  del_go;
  logic [CntW-1:0]       pos_hit;
  logic [CntW-1:0]       position;
  bst_pkg::cell_ctrl_t   ctrl;

  logic [CAPACITY_ENTRIES-1:0] hit;
  logic [CAPACITY_ENTRIES:0]   seen;
  logic [VALUE_BITS-1:0]       entry [CAPACITY_ENTRIES+1];

  // keep only the low value bits, zero-extend when the store is wider
  if (VALUE_BITS <= 32) begin : g_key_narrow
    assign key = s_axis_tdata[VALUE_BITS-1:0];
  end else begin : g_key_wide
    assign key = {{(VALUE_BITS-32){1'b0}}, s_axis_tdata};
  end

  assign mode          = bst_pkg::mode_e'(s_axis_tuser);
  // result register frees up in the same cycle it is taken
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // row of cells; the hit flag ripples upward from cell zero
  assign seen[0]                 = 1'b0;
  assign entry[CAPACITY_ENTRIES] = '0;

  for (genvar g = 0; g < CAPACITY_ENTRIES; g++) begin : g_cell
    bst_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CntW),
      .IDX        (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_i        (key),
      .count_i      (count_q),
      .seen_i       (seen[g]),
      .next_entry_i (entry[g+1]),
      .hit_o        (hit[g]),
      .seen_o       (seen[g+1]),
      .entry_o      (entry[g])
    );
  end

  assign found = seen[CAPACITY_ENTRIES];

  // stored values are distinct, so at most one hit: or the indexes together
  always_comb begin
    pos_hit = '0;
    for (int i = 0; i < CAPACITY_ENTRIES; i++) begin
      if (hit[i]) begin
        pos_hit = pos_hit | CntW'(i);
      end
    end
  end

  assign position = found ? pos_hit : count_q;

  assign ins_go = s_fire && (mode == bst_pkg::MODE_INSERT) && !found &&
                  (count_q < CntW'(CAPACITY_ENTRIES));
  assign del_go = s_fire && (mode == bst_pkg::MODE_DELETE) && found;

  assign ctrl.ins_en = ins_go;
  assign ctrl.del_op = s_fire && (mode == bst_pkg::MODE_DELETE);

  always_comb begin
    count_d = count_q;
    if (ins_go) begin
      count_d = count_q + CntW'(1);
    end else if (del_go) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_data_d       = '0;
    out_data_d[0]    = found;
    out_data_d[6:1]  = FW'(position);
    out_data_d[12:7] = FW'(count_d);
    out_data_d[13]   = ins_go || del_go;
    out_data_d[14]   = count_d == CntW'(CAPACITY_ENTRIES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  `BST_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY_ENTRIES), "fill count past capacity")
  `BST_ASSERT(a_single_hit, $onehot0(hit), "value held in more than one cell")
  `BST_ASSERT_NEXT(a_ins_grows, ins_go, count_q == $past(count_q) + CntW'(1), "insert lost")
  `BST_ASSERT_NEXT(a_del_shrinks, del_go, count_q == $past(count_q) - CntW'(1), "delete lost")
  `BST_ASSERT_NEXT(a_result_held, s_fire, m_axis_tvalid, "result missing after transfer")

endmodule

`default_nettype wire

@@ src/bst_cell.sv @@
// one storage cell of the set table: entry, compare and shift-down
`default_nettype none

module bst_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned CNT_W      = 6,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                    clk_i,
  input  wire bst_pkg::cell_ctrl_t     ctrl_i,
  input  wire logic [VALUE_BITS-1:0]   key_i,
  input  wire logic [CNT_W-1:0]        count_i,
  input  wire logic                    seen_i,
  input  wire logic [VALUE_BITS-1:0]   next_entry_i,
  output logic                         hit_o,
  output logic                         seen_o,
  output logic [VALUE_BITS-1:0]        entry_o
);

  logic [VALUE_BITS-1:0] entry_q, entry_d;
  logic                  in_use;
  logic                  at_tail;

  assign in_use  = CNT_W'(IDX) < count_i;
  assign at_tail = CNT_W'(IDX) == count_i;
  assign hit_o   = in_use && (entry_q == key_i);
  // hit seen at this cell or any lower one
  assign seen_o  = seen_i | hit_o;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.del_op && seen_o) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.ins_en && at_tail) begin
      entry_d = key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

@@ dv/bounded_set_table_tb.sv @@
// testbench for the bounded set table: predicted lookup results checked on every result transfer
`default_nettype none

module bounded_set_table_tb;

  localparam int unsigned Capacity       = 32;
  localparam logic [1:0]  ModeSpare      = 2'd3;  // unused code, behaves as a query
  localparam int unsigned PoolSize       = 36;
  localparam int unsigned BlocksPerPhase = 10;
  localparam int unsigned ItemsPerBlock  = 51;
  localparam int unsigned CycleLimit     = 200000;

  // one result transfer, lowest field in bit 0
  typedef struct packed {
    logic       pad;
    logic       full_res;
    logic       changed;
    logic [5:0] fill_count;
    logic [5:0] position;
    logic       found;
  } lookup_res_t;

  // mirror of the table contents plus the results still owed by the block
  class set_table_model;
    logic [31:0] held [Capacity];
    int unsigned held_count = 0;
    lookup_res_t awaited[$];
    int unsigned mismatches = 0;

    // one accepted operation: update the mirror and queue the result it must produce
    function void apply_op(logic [1:0] mode, logic [31:0] value);
      int unsigned idx;
      lookup_res_t res;
      idx = 0;
      while (idx < held_count && held[idx] != value) idx++;
      res = '0;
      res.found = idx < held_count;
      res.position = idx[5:0];
      if (mode == bst_pkg::MODE_INSERT && !res.found && held_count < Capacity) begin
        held[held_count] = value;
        held_count++;
        res.changed = 1'b1;
      end else if (mode == bst_pkg::MODE_DELETE && res.found) begin
        // later entries close the gap
        for (int unsigned k = idx; k + 1 < held_count; k++) held[k] = held[k + 1];
        held_count--;
        res.changed = 1'b1;
      end
      res.fill_count = held_count[5:0];
      res.full_res = held_count == Capacity;
      awaited.push_back(res);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      mismatches++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task check_result(logic [15:0] word);
      lookup_res_t got, want;
      got = word;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result, word", word, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.found != want.found) report_mismatch("found", got.found, want.found);
      if (got.position != want.position)
        report_mismatch("position", got.position, want.position);
      if (got.fill_count != want.fill_count)
        report_mismatch("fill_count", got.fill_count, want.fill_count);
      if (got.changed != want.changed) report_mismatch("changed", got.changed, want.changed);
      if (got.full_res != want.full_res)
        report_mismatch("full_res", got.full_res, want.full_res);
      if (got.pad != 1'b0) report_mismatch("padding bit", got.pad, 0);
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic [15:0] m_axis_tdata;

  set_table_model lookups = new();

  logic [31:0] value_pool [PoolSize];
  int unsigned valid_idle_pct = 11;
  int unsigned ready_idle_pct = 57;
  int unsigned cycle_count    = 0;

  bounded_set_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= $urandom_range(0, 99) >= ready_idle_pct;
  end

  // every result transfer is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) lookups.check_result(m_axis_tdata);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("bounded_set_table_tb failed");
      $finish;
    end
  end

  // offer one operation, with a random gap first, and hold it until it transfers;
  // tvalid stays high afterwards so back-to-back items need no second assignment
  task automatic send_op(input logic [1:0] mode, input logic [31:0] value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < valid_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= $urandom;  // junk while idle must be ignored
      s_axis_tuser <= 2'($urandom_range(0, 3));
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    s_axis_tuser <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lookups.apply_op(mode, value);
  endtask

  // hold off the sender until every outstanding result is back
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (lookups.awaited.size() != 0) @(posedge clk_i);
  endtask

  // mostly values from a small pool so that hits, duplicates and a full table occur
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return value_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  function automatic logic [1:0] pick_mode(int unsigned ins_w, int unsigned del_w);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_w) return bst_pkg::MODE_INSERT;
    if (roll < ins_w + del_w) return bst_pkg::MODE_DELETE;
    if (roll < 97) return bst_pkg::MODE_QUERY;
    return ModeSpare;
  endfunction

  initial begin
    int unsigned ins_w, del_w;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) value_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extreme values, duplicates, spare mode, deletes at the front, middle and end
    send_op(bst_pkg::MODE_QUERY,  32'h0000_0000);
    send_op(bst_pkg::MODE_DELETE, 32'h0000_0000);
    send_op(bst_pkg::MODE_INSERT, 32'h0000_0000);
    send_op(bst_pkg::MODE_INSERT, 32'hFFFF_FFFF);
    send_op(bst_pkg::MODE_INSERT, 32'hAAAA_AAAA);
    send_op(bst_pkg::MODE_INSERT, 32'h5555_5555);
    send_op(bst_pkg::MODE_INSERT, 32'h0000_0000);
    send_op(bst_pkg::MODE_QUERY,  32'hFFFF_FFFF);
    send_op(ModeSpare,            32'hFFFF_FFFF);
    send_op(ModeSpare,            32'h1234_5678);
    send_op(bst_pkg::MODE_QUERY,  32'h1234_5678);
    send_op(bst_pkg::MODE_DELETE, 32'h0000_0000);
    send_op(bst_pkg::MODE_DELETE, 32'h0000_0000);
    send_op(bst_pkg::MODE_QUERY,  32'h5555_5555);
    send_op(bst_pkg::MODE_DELETE, 32'h5555_5555);
    send_op(bst_pkg::MODE_INSERT, 32'h0000_0000);
    send_op(bst_pkg::MODE_DELETE, 32'hAAAA_AAAA);
    send_op(bst_pkg::MODE_QUERY,  32'h0000_0000);
    send_op(bst_pkg::MODE_DELETE, 32'hFFFF_FFFF);
    send_op(bst_pkg::MODE_DELETE, 32'h0000_0000);
    pause_until_drained();

    // random: sender idles lightly, then heavily, then not at all (receiver heavily, then lightly, then not at all)
    for (int phase = 0; phase < 3; phase++) begin
      valid_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 57 : 0;
      ready_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 11 : 0;
      for (int blk = 0; blk < BlocksPerPhase; blk++) begin
        // two fill blocks in a row push the table to full, then mixed, then drain
        case (blk % 4)
          0, 1: begin
            ins_w = 85;
            del_w = 5;
          end
          2: begin
            ins_w = 35;
            del_w = 35;
          end
          default: begin
            ins_w = 10;
            del_w = 75;
          end
        endcase
        repeat (ItemsPerBlock) send_op(pick_mode(ins_w, del_w), pick_value());
      end
      pause_until_drained();
    end

    repeat (4) @(posedge clk_i);
    if (lookups.mismatches == 0 && lookups.awaited.size() == 0) begin
      $display("bounded_set_table_tb passed");
    end else begin
      $display("bounded_set_table_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
